### sv/positional_list_store_macros.svh
// ----------------------------------------------------------------------------
// Positional list store assertion macros
// Concurrent checks used by the list store RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list store check failed");
// next-cycle implication
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list store check failed");
// invariant
`define PLS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("list store check failed");
`else
`define PLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define PLS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

### sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Beat types, command codes and sizing constants shared by the list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int GROUP_SIZE   = 32;
    localparam int POS_W        = 7;
    localparam int WORD_W       = 32;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                     command;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] value_out;
        logic [COUNT_W-1:0]       element_count;
    } rsp_t;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic read_en;
    } ctl_t;

endpackage

### sv/pls_cell.sv
// ----------------------------------------------------------------------------
// List store cell
// Holds one entry; loads the new value, its left or its right neighbor when
// the list opens or closes a gap, and offers its word when a read selects it.
// ----------------------------------------------------------------------------
module pls_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 8
) (
    input  logic                             clk,
    input  pls_pkg::ctl_t                    ctl,
    input  logic [CMP_W-1:0]                 pos,
    input  logic signed [pls_pkg::WORD_W-1:0] value,
    input  logic signed [pls_pkg::WORD_W-1:0] left,
    input  logic signed [pls_pkg::WORD_W-1:0] right,
    output logic signed [pls_pkg::WORD_W-1:0] data,
    output logic [pls_pkg::WORD_W-1:0]        rd_word
);

    logic signed [pls_pkg::WORD_W-1:0] data_reg;
    logic signed [pls_pkg::WORD_W-1:0] data_next;
    logic                              hit;
    logic                              above;

    assign hit   = (pos == CMP_W'(INDEX));
    assign above = (CMP_W'(INDEX) > pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            if (above)
                data_next = left;
            else if (hit)
                data_next = value;
        end
        else if (ctl.shift_down)
        begin
            if (above || hit)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_word = (ctl.read_en && hit) ? data_reg : '0;

endmodule

### sv/pls_gather.sv
// ----------------------------------------------------------------------------
// List store read gather
// OR-collects the selected cell word: one registered level over groups of
// cells, then a final OR over the group registers.
// ----------------------------------------------------------------------------
module pls_gather #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
    parameter int GROUP    = pls_pkg::GROUP_SIZE
) (
    input  logic                        clk,
    input  logic [pls_pkg::WORD_W-1:0]  words [CAPACITY],
    output logic [pls_pkg::WORD_W-1:0]  word
);

    localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam int PADDED  = NGROUPS * GROUP;

    logic [pls_pkg::WORD_W-1:0] pad       [PADDED];
    logic [pls_pkg::WORD_W-1:0] group_next[NGROUPS];
    logic [pls_pkg::WORD_W-1:0] group_reg [NGROUPS];

    genvar k;
    genvar g;

    generate
        for (k = 0; k < PADDED; k++)
        begin : g_pad
            if (k < CAPACITY)
            begin : g_word
                assign pad[k] = words[k];
            end
            else
            begin : g_zero
                assign pad[k] = '0;
            end
        end

        for (g = 0; g < NGROUPS; g++)
        begin : g_group
            always_comb
            begin
                group_next[g] = '0;
                for (int j = 0; j < GROUP; j++)
                    group_next[g] = group_next[g] | pad[g*GROUP + j];
            end

            always_ff @(posedge clk)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    endgenerate

    // at most one cell is selected, so OR acts as the read mux
    always_comb
    begin
        word = '0;
        for (int n = 0; n < NGROUPS; n++)
            word = word | group_reg[n];
    end

endmodule

### sv/positional_list_store.sv
// ----------------------------------------------------------------------------
// Positional list store
// Ordered list of signed words kept in a row of cells; append, insert,
// remove and read by position.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a command beat on req and raise start; the beat is taken at the
//   clock edge where start is high and busy is low. busy stays low, so a
//   new beat may be issued every cycle.
//   Each beat returns exactly one beat on rsp, marked by done for a single
//   cycle, through the s1 and done registers; results leave in issue order.
//   Throughput is one command per cycle: every cell updates from its own
//   word or a neighbor in the cycle the command is taken, and a read goes
//   through one registered OR level over groups of GROUP_SIZE cells.
//   rsp carries ok (command carried out), value_out (read word, zero for
//   any other command or a refused read) and element_count after the beat.
//   Refused: append or insert when full, insert past the end, remove or
//   read at or beyond the count.
//   Reset empties the list and drops beats in flight; cell contents are
//   not cleared and are never seen before being written.
//   The receiver cannot stall: done is not held off.
// ----------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pls_pkg::req_t req,
    output logic          done,
    output pls_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

    logic                              accept;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [CMP_W-1:0]                  pos_ext;
    logic [CMP_W-1:0]                  cnt_ext;
    logic [CMP_W-1:0]                  cell_pos;
    logic                              full;
    logic                              ok;
    pls_pkg::ctl_t                     ctl;

    logic signed [pls_pkg::WORD_W-1:0] cell_data [CAPACITY];
    logic [pls_pkg::WORD_W-1:0]        rd_words  [CAPACITY];
    logic [pls_pkg::WORD_W-1:0]        rd_word;

    logic                              s1_valid_reg;
    logic                              s1_ok_reg;
    logic [pls_pkg::COUNT_W-1:0]       s1_count_reg;
    logic                              done_reg;
    pls_pkg::rsp_t                     rsp_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ok         = 1'b0;
        ctl        = '0;
        cell_pos   = pos_ext;
        count_next = count_reg;
        case (req.command)
            pls_pkg::CMD_APPEND:
            begin
                // append is an insert at the current end
                ok           = !full;
                cell_pos     = cnt_ext;
                ctl.shift_up = accept && ok;
            end
            pls_pkg::CMD_INSERT:
            begin
                ok           = (pos_ext <= cnt_ext) && !full;
                ctl.shift_up = accept && ok;
            end
            pls_pkg::CMD_REMOVE:
            begin
                ok             = (pos_ext < cnt_ext);
                ctl.shift_down = accept && ok;
            end
            pls_pkg::CMD_READ:
            begin
                ok          = (pos_ext < cnt_ext);
                ctl.read_en = accept && ok;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (ctl.shift_up)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.shift_down)
            count_next = count_reg - CNT_W'(1);
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [pls_pkg::WORD_W-1:0] left_w;
            logic signed [pls_pkg::WORD_W-1:0] right_w;

            if (i == 0)
            begin : g_first
                assign left_w = req.value_in;
            end
            else
            begin : g_left
                assign left_w = cell_data[i-1];
            end

            // last cell has no right neighbor: hold
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_data[i];
            end
            else
            begin : g_right
                assign right_w = cell_data[i+1];
            end

            pls_cell #(
                .INDEX (i),
                .CMP_W (CMP_W)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .pos     (cell_pos),
                .value   (req.value_in),
                .left    (left_w),
                .right   (right_w),
                .data    (cell_data[i]),
                .rd_word (rd_words[i])
            );
        end
    endgenerate

    pls_gather #(
        .CAPACITY (CAPACITY),
        .GROUP    (pls_pkg::GROUP_SIZE)
    ) u_gather (
        .clk   (clk),
        .words (rd_words),
        .word  (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg         <= ok;
        s1_count_reg      <= pls_pkg::COUNT_W'(count_next);
        rsp_reg.ok            <= s1_ok_reg;
        rsp_reg.value_out     <= rd_word;
        rsp_reg.element_count <= s1_count_reg;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `PLS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY))
    `PLS_ASSERT_IMPLIES(a_result_due, clk, rst_n, accept, ##2 done)
    `PLS_ASSERT_NEXT(a_count_hold, clk, rst_n, !accept, $stable(count_reg))
    `PLS_ASSERT_IMPLIES(a_word_needs_ok, clk, rst_n, done && (rsp.value_out != 0), rsp.ok)

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// Positional list store testbench
// Drives append, insert, remove and read beats into the list store, predicts
// each result from a shadow copy of the list (pinned table rows carry their
// own) and checks each done beat field by field. A directed table comes first,
// then random grow and shrink runs under three sender idling profiles.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIST_CAP   = pls_pkg::CAPACITY_DEF;
    localparam int RAND_BEATS = 1980;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 8;

    typedef struct {
        pls_pkg::req_t beat;
        bit            pinned;
        pls_pkg::rsp_t want;
    } row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    pls_pkg::req_t  req;
    logic           done;
    pls_pkg::rsp_t  rsp;

    // typed expectation that travels with the beat currently driven
    bit             pin_valid;
    pls_pkg::rsp_t  pin_rsp;

    // shadow list
    logic signed [pls_pkg::WORD_W-1:0] shadow_words [LIST_CAP];
    int                                shadow_len;

    pls_pkg::rsp_t pending_rsp [$];
    row_t          dir_rows [$];
    int unsigned   idle_pct;
    int unsigned   mismatch_cnt;
    int unsigned   beats_taken;
    int unsigned   results_seen;
    int unsigned   refused_cnt;
    int unsigned   full_refusals;
    int unsigned   read_hits;
    int unsigned   quiet_cycles;

    positional_list_store #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #1 clk = ~clk;

    function automatic pls_pkg::rsp_t apply_command(pls_pkg::req_t r);
        pls_pkg::rsp_t res;
        int            p;
        int            k;
        res = '0;
        p   = r.position;
        case (r.command)
            pls_pkg::CMD_APPEND:
            begin
                if (shadow_len < LIST_CAP)
                begin
                    shadow_words[shadow_len] = r.value_in;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            pls_pkg::CMD_INSERT:
            begin
                if (p <= shadow_len && shadow_len < LIST_CAP)
                begin
                    for (k = shadow_len; k > p; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[p] = r.value_in;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            pls_pkg::CMD_REMOVE:
            begin
                if (p < shadow_len)
                begin
                    for (k = p; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                if (p < shadow_len)
                begin
                    res.value_out = shadow_words[p];
                    res.ok        = 1'b1;
                end
            end
        endcase
        res.element_count = pls_pkg::COUNT_W'(shadow_len);
        return res;
    endfunction

    function automatic void add_row(pls_pkg::cmd_t c, int unsigned p,
                                    logic [pls_pkg::WORD_W-1:0] v,
                                    bit pin, bit ok_w, logic [pls_pkg::WORD_W-1:0] rd_w,
                                    int unsigned cnt_w);
        row_t r;
        r.beat.command          = c;
        r.beat.position         = pls_pkg::POS_W'(p);
        r.beat.value_in         = v;
        r.pinned                = pin;
        r.want.ok               = ok_w;
        r.want.value_out        = rd_w;
        r.want.element_count    = pls_pkg::COUNT_W'(cnt_w);
        dir_rows.push_back(r);
    endfunction

    // Check results, take beats and run the watchdog.
    always @(posedge clk)
    begin : monitor_blk
        pls_pkg::rsp_t want;
        pls_pkg::rsp_t pred;
        bit            took;
        if (rst_n)
        begin
            took = start && !busy;
            if (done)
            begin
                results_seen++;
                if (pending_rsp.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("tb: result with nothing pending: ok=%0b val=%h cnt=%0d",
                                 rsp.ok, rsp.value_out, rsp.element_count);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.ok !== want.ok || rsp.value_out !== want.value_out
                        || rsp.element_count !== want.element_count)
                    begin
                        if (mismatch_cnt < 10)
                            $display({"tb: result %0d mismatch: ok %0b/%0b ",
                                      "value_out %h/%h element_count %0d/%0d (exp/got)"},
                                     results_seen, want.ok, rsp.ok, want.value_out,
                                     rsp.value_out, want.element_count, rsp.element_count);
                        mismatch_cnt++;
                    end
                end
            end
            if (took)
            begin
                pred = apply_command(req);
                beats_taken++;
                if (!pred.ok)
                begin
                    refused_cnt++;
                    if ((req.command == pls_pkg::CMD_APPEND
                         || req.command == pls_pkg::CMD_INSERT)
                        && shadow_len == LIST_CAP)
                        full_refusals++;
                end
                else if (req.command == pls_pkg::CMD_READ)
                    read_hits++;
                pending_rsp.push_back(pin_valid ? pin_rsp : pred);
            end
            if (took || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Keep start high across back-to-back beats; lower it only while idling.
    task automatic send_beat(input pls_pkg::req_t r, input bit pin,
                             input pls_pkg::rsp_t pinned);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        req       <= r;
        pin_valid <= pin;
        pin_rsp   <= pinned;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off until every pending result is back; first wait for the last
    // beat to be queued.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic pls_pkg::req_t random_beat(bit grow);
        pls_pkg::req_t r;
        int unsigned   roll;
        int unsigned   len;
        len  = shadow_len;
        roll = $urandom_range(99);
        if (grow)
        begin
            if (roll < 35)      r.command = pls_pkg::CMD_APPEND;
            else if (roll < 70) r.command = pls_pkg::CMD_INSERT;
            else if (roll < 80) r.command = pls_pkg::CMD_REMOVE;
            else                r.command = pls_pkg::CMD_READ;
        end
        else
        begin
            if (roll < 10)      r.command = pls_pkg::CMD_APPEND;
            else if (roll < 20) r.command = pls_pkg::CMD_INSERT;
            else if (roll < 70) r.command = pls_pkg::CMD_REMOVE;
            else                r.command = pls_pkg::CMD_READ;
        end
        roll = $urandom_range(99);
        if (roll < 70)
            r.position = pls_pkg::POS_W'($urandom_range(len, 0));
        else if (roll < 80)
            r.position = pls_pkg::POS_W'(len);
        else
            r.position = pls_pkg::POS_W'($urandom_range((1 << pls_pkg::POS_W) - 1, 0));
        r.value_in = $urandom();
        return r;
    endfunction

    initial
    begin : stim_blk
        pls_pkg::rsp_t no_pin;
        int            ph;
        int            n;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        pin_valid    = 1'b0;
        pin_rsp      = '0;
        no_pin       = '0;
        shadow_len   = 0;
        idle_pct     = 33;
        mismatch_cnt = 0;
        beats_taken  = 0;
        results_seen = 0;
        refused_cnt  = 0;
        full_refusals = 0;
        read_hits    = 0;
        quiet_cycles = 0;

        // empty list, edge values and every refusal but those on a full list
        add_row(pls_pkg::CMD_READ,     0, 32'h0,          1, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_REMOVE,   0, 32'h0,          1, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_INSERT,   1, 32'h1234_5678,  1, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_APPEND,   0, 32'h7FFF_FFFF,  1, 1, 32'h0,          1);
        add_row(pls_pkg::CMD_APPEND,   0, 32'h8000_0000,  1, 1, 32'h0,          2);
        add_row(pls_pkg::CMD_INSERT,   0, 32'hFFFF_FFFF,  1, 1, 32'h0,          3);
        add_row(pls_pkg::CMD_INSERT,   3, 32'h0,          1, 1, 32'h0,          4);
        add_row(pls_pkg::CMD_READ,     0, 32'h0,          1, 1, 32'hFFFF_FFFF,  4);
        add_row(pls_pkg::CMD_READ,     1, 32'h0,          1, 1, 32'h7FFF_FFFF,  4);
        add_row(pls_pkg::CMD_READ,     2, 32'h0,          1, 1, 32'h8000_0000,  4);
        add_row(pls_pkg::CMD_READ,     3, 32'hFFFF_FFFF,  1, 1, 32'h0,          4);
        add_row(pls_pkg::CMD_READ,     4, 32'h0,          1, 0, 32'h0,          4);
        add_row(pls_pkg::CMD_READ,   127, 32'h0,          1, 0, 32'h0,          4);
        add_row(pls_pkg::CMD_INSERT,   5, 32'h0,          1, 0, 32'h0,          4);
        add_row(pls_pkg::CMD_INSERT,   2, 32'h5A5A_5A5A,  0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_REMOVE,   4, 32'h0,          0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_REMOVE,   0, 32'h0,          0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_READ,     0, 32'h0,          0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_READ,     1, 32'h0,          0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_READ,     2, 32'h0,          0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_READ,     3, 32'h0,          0, 0, 32'h0,          0);
        add_row(pls_pkg::CMD_INSERT, 127, 32'hFFFF_FFFF,  1, 0, 32'h0,          3);
        add_row(pls_pkg::CMD_APPEND,   0, 32'h0,          0, 0, 32'h0,          0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);
        drain();

        // alternate grow-heavy and shrink-heavy runs so full and empty recur
        for (ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 33 : (ph == 1) ? 88 : 0;
            for (n = 0; n < RAND_BEATS / 3; n++)
                send_beat(random_beat(((n / 100) % 2) == 0), 1'b0, no_pin);
            drain();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $display("tb: %0d results never arrived", pending_rsp.size());
            mismatch_cnt++;
        end
        $display("tb: %0d beats taken, %0d results checked, %0d refused",
                 beats_taken, results_seen, refused_cnt);
        $display("tb: %0d refusals on a full list, %0d successful reads, %0d mismatches",
                 full_refusals, read_hits, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
